>>> hw/rtl/kruf_pkg.sv
`default_nettype none

package kruf_pkg;

  // fixed field widths
  localparam int VTX_W    = 6;
  localparam int WGT_W    = 16;
  localparam int SUM_W    = 32;
  localparam int CNT_W    = 7;
  localparam int VCNT_W   = 7;
  localparam int RANK_W   = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = '1;

  // epoch tags mark which graph wrote a forest entry; tag zero is never current
  localparam int EPOCH_W  = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  // saturation limits of the running total
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // controls from the sequencer to the totals
  typedef struct packed {
    logic clear;
    logic add;
  } acc_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/kruf_forest_mem.sv
`default_nettype none

module kruf_forest_mem #(
  parameter int DEPTH = 64,
  parameter int VW    = 6
) (
  input  wire logic                          clk,
  // request: {we, sweep, waddr, wrank, wparent, raddr}
  input  wire logic [2*kruf_pkg::RANK_W/kruf_pkg::RANK_W+3*VW+kruf_pkg::RANK_W-1:0] req,
  input  wire logic [kruf_pkg::EPOCH_W-1:0]  epoch,
  output logic      [VW-1:0]                 rd_parent,
  output logic      [kruf_pkg::RANK_W-1:0]   rd_rank
);

  typedef struct packed {
    logic                        we;
    logic                        sweep;
    logic [VW-1:0]               waddr;
    logic [kruf_pkg::RANK_W-1:0] wrank;
    logic [VW-1:0]               wparent;
    logic [VW-1:0]               raddr;
  } mem_req_t;

  typedef struct packed {
    logic [kruf_pkg::EPOCH_W-1:0] tag;
    logic [kruf_pkg::RANK_W-1:0]  rank;
    logic [VW-1:0]                parent;
  } entry_t;

  mem_req_t r;
  entry_t   mem [DEPTH];
  entry_t   rd_word;
  entry_t   wr_word;
  logic [VW-1:0] rd_addr;
  logic     rd_valid;

  assign r = mem_req_t'(req);

  // sweep writes carry a tag that no graph uses
  always_comb begin
    wr_word.tag    = r.sweep ? kruf_pkg::EPOCH_NONE : epoch;
    wr_word.rank   = r.wrank;
    wr_word.parent = r.wparent;
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (r.we) begin
      mem[r.waddr] <= wr_word;
    end
    rd_word <= mem[r.raddr];
    rd_addr <= r.raddr;
  end

  // an entry from another graph reads as a root of rank zero
  assign rd_valid  = (rd_word.tag == epoch);
  assign rd_parent = rd_valid ? rd_word.parent : rd_addr;
  assign rd_rank   = rd_valid ? rd_word.rank : '0;

endmodule

`default_nettype wire

>>> hw/rtl/kruf_accum.sv
`default_nettype none

module kruf_accum (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire kruf_pkg::acc_ctl_t                  ctl,
  input  wire logic signed [kruf_pkg::WGT_W-1:0]   weight,
  output logic signed      [kruf_pkg::SUM_W-1:0]   sum,
  output logic             [kruf_pkg::CNT_W-1:0]   count
);

  logic signed [kruf_pkg::SUM_W:0] wide;
  logic signed [kruf_pkg::SUM_W-1:0] sum_next;

  // one extra bit shows overflow in either direction
  always_comb begin
    wide = {sum[kruf_pkg::SUM_W-1], sum}
         + {{(kruf_pkg::SUM_W+1-kruf_pkg::WGT_W){weight[kruf_pkg::WGT_W-1]}}, weight};
    case (wide[kruf_pkg::SUM_W:kruf_pkg::SUM_W-1])
      2'b01:   sum_next = kruf_pkg::SUM_MAX;
      2'b10:   sum_next = kruf_pkg::SUM_MIN;
      default: sum_next = wide[kruf_pkg::SUM_W-1:0];
    endcase
  end

  // running total and edge count
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sum   <= '0;
      count <= '0;
    end else if (ctl.add) begin
      sum   <= sum_next;
      count <= count + kruf_pkg::CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/kruskal_union_find_edge_filter.sv
// An accepted edge passes S_START, then S_FIND and S_COMP for each end in turn, S_UNION,
// S_RANK when two equal ranks merge, and S_EMIT; an edge rejected at the range or count check
// goes from S_START straight to S_EMIT. One edge is in work at a time; the next is accepted in
// the cycle after its result is registered, output stalls apart.
// Reset (synchronous, active high) runs a clearing pass over every entry of the forest memory;
// the same pass runs at every fifteenth new graph when the epoch tags wrap.
`default_nettype none

module kruskal_union_find_edge_filter #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // first_vertex [5:0], second_vertex [11:6], edge_weight [27:12], zero [31:28]
  input  wire logic [31:0] s_tdata,
  // new_graph [0]
  input  wire logic        s_tuser,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // total_weight [31:0], edges_taken [37:32], tree_complete [38], zero [39]
  output logic      [39:0] m_tdata,
  // taken [0]
  output logic             m_tuser,
  output logic             m_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [6:0]  cfg_data
);

  localparam int VW   = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int NCAP = (MAX_VERTICES < 127) ? MAX_VERTICES : 127;
  localparam logic [kruf_pkg::VCNT_W-1:0] NCAP_V   = kruf_pkg::VCNT_W'(NCAP);
  localparam logic [VW-1:0]               LAST_IDX = VW'(MAX_VERTICES - 1);

  typedef enum logic [7:0] {
    S_SWEEP = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_START = 8'b0000_0100,
    S_FIND  = 8'b0000_1000,
    S_COMP  = 8'b0001_0000,
    S_UNION = 8'b0010_0000,
    S_RANK  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic                        we;
    logic                        sweep;
    logic [VW-1:0]               waddr;
    logic [kruf_pkg::RANK_W-1:0] wrank;
    logic [VW-1:0]               wparent;
    logic [VW-1:0]               raddr;
  } mem_req_t;

  state_t state, state_next;
  logic   busy, busy_next;
  logic [kruf_pkg::VCNT_W-1:0]  vcount;
  logic [kruf_pkg::EPOCH_W-1:0] epoch, epoch_next;
  logic [VW-1:0] sweep_idx, sweep_idx_next;
  logic [kruf_pkg::VTX_W-1:0] va, vb;
  logic signed [kruf_pkg::WGT_W-1:0] wt;
  logic lastf;
  logic [VW-1:0] cur, cur_next;
  logic which, which_next;
  logic rd_pend, rd_pend_next;
  logic [VW-1:0] root_a, root_a_next, root_b, root_b_next;
  logic [kruf_pkg::RANK_W-1:0] rank_a, rank_a_next, rank_b, rank_b_next;
  logic taken, taken_next;

  mem_req_t req;
  logic [VW-1:0] rd_parent;
  logic [kruf_pkg::RANK_W-1:0] rd_rank;
  kruf_pkg::acc_ctl_t acc_ctl;
  logic signed [kruf_pkg::SUM_W-1:0] sum;
  logic [kruf_pkg::CNT_W-1:0] count;

  logic s_acc, out_free;
  logic [kruf_pkg::VCNT_W-1:0] n_eff, limit;
  logic eligible;
  logic [VW-1:0] cur_root, other_start;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // effective vertex count, edge limit, eligibility and search operands
  always_comb begin
    if (vcount == '0) begin
      n_eff = kruf_pkg::VCNT_W'(1);
    end else if (vcount > NCAP_V) begin
      n_eff = NCAP_V;
    end else begin
      n_eff = vcount;
    end
    limit    = n_eff - kruf_pkg::VCNT_W'(1);
    eligible = (count < limit) && ({1'b0, va} < n_eff) && ({1'b0, vb} < n_eff);
    cur_root    = which ? root_b : root_a;
    other_start = VW'(vb);
  end

  // sequencer: clearing sweep, epoch update, root searches, path rewriting and the merge
  always_comb begin
    state_next     = state;
    busy_next      = busy;
    epoch_next     = epoch;
    sweep_idx_next = sweep_idx;
    cur_next       = cur;
    which_next     = which;
    rd_pend_next   = rd_pend;
    root_a_next    = root_a;
    root_b_next    = root_b;
    rank_a_next    = rank_a;
    rank_b_next    = rank_b;
    taken_next     = taken;
    req            = '0;
    req.raddr      = cur;
    acc_ctl        = '0;

    case (state)
      S_SWEEP: begin
        req.we         = 1'b1;
        req.sweep      = 1'b1;
        req.waddr      = sweep_idx;
        sweep_idx_next = sweep_idx + VW'(1);
        if (sweep_idx == LAST_IDX) begin
          sweep_idx_next = '0;
          epoch_next     = kruf_pkg::EPOCH_FIRST;
          state_next     = busy ? S_START : S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_acc) begin
          busy_next     = 1'b1;
          acc_ctl.clear = s_tuser;
          state_next    = S_START;
          if (s_tuser) begin
            if (epoch == kruf_pkg::EPOCH_LAST) begin
              state_next = S_SWEEP;
            end else begin
              epoch_next = epoch + kruf_pkg::EPOCH_W'(1);
            end
          end
        end
      end
      S_START: begin
        taken_next   = 1'b0;
        which_next   = 1'b0;
        rd_pend_next = 1'b0;
        cur_next     = VW'(va);
        state_next   = eligible ? S_FIND : S_EMIT;
      end
      S_FIND: begin
        if (!rd_pend) begin
          req.raddr    = cur;
          rd_pend_next = 1'b1;
        end else if (rd_parent == cur) begin
          // root reached: rewrite the path from the start vertex
          if (which) begin
            root_b_next = cur;
            rank_b_next = rd_rank;
            cur_next    = other_start;
          end else begin
            root_a_next = cur;
            rank_a_next = rd_rank;
            cur_next    = VW'(va);
          end
          rd_pend_next = 1'b0;
          state_next   = S_COMP;
        end else begin
          cur_next  = rd_parent;
          req.raddr = rd_parent;
        end
      end
      S_COMP: begin
        if (!rd_pend && (cur == cur_root)) begin
          rd_pend_next = 1'b0;
          if (which) begin
            state_next = S_UNION;
          end else begin
            which_next = 1'b1;
            cur_next   = other_start;
            state_next = S_FIND;
          end
        end else if (!rd_pend) begin
          req.raddr    = cur;
          rd_pend_next = 1'b1;
        end else begin
          // point this entry at the root and move on to its old parent
          req.we      = 1'b1;
          req.waddr   = cur;
          req.wrank   = rd_rank;
          req.wparent = cur_root;
          cur_next    = rd_parent;
          req.raddr   = rd_parent;
          if (rd_parent == cur_root) begin
            rd_pend_next = 1'b0;
            if (which) begin
              state_next = S_UNION;
            end else begin
              which_next = 1'b1;
              cur_next   = other_start;
              state_next = S_FIND;
            end
          end
        end
      end
      S_UNION: begin
        if (root_a == root_b) begin
          state_next = S_EMIT;
        end else begin
          taken_next  = 1'b1;
          acc_ctl.add = 1'b1;
          req.we      = 1'b1;
          state_next  = S_EMIT;
          if (rank_a < rank_b) begin
            req.waddr   = root_a;
            req.wrank   = rank_a;
            req.wparent = root_b;
          end else begin
            req.waddr   = root_b;
            req.wrank   = rank_b;
            req.wparent = root_a;
            if (rank_a == rank_b) begin
              state_next = S_RANK;
            end
          end
        end
      end
      S_RANK: begin
        // equal ranks: the surviving root grows by one, saturating
        req.we      = 1'b1;
        req.waddr   = root_a;
        req.wparent = root_a;
        req.wrank   = (rank_a == kruf_pkg::RANK_MAX) ? rank_a
                    : rank_a + kruf_pkg::RANK_W'(1);
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          busy_next  = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_SWEEP;
      busy      <= 1'b0;
      epoch     <= kruf_pkg::EPOCH_FIRST;
      sweep_idx <= '0;
      rd_pend   <= 1'b0;
      which     <= 1'b0;
      vcount    <= kruf_pkg::VCNT_W'(64);
    end else begin
      state     <= state_next;
      busy      <= busy_next;
      epoch     <= epoch_next;
      sweep_idx <= sweep_idx_next;
      rd_pend   <= rd_pend_next;
      which     <= which_next;
      if (cfg_valid && cfg_ready) begin
        vcount <= cfg_data;
      end
    end
  end

  // edge payload and working values
  always_ff @(posedge clk) begin
    if (s_acc) begin
      va    <= s_tdata[5:0];
      vb    <= s_tdata[11:6];
      wt    <= s_tdata[27:12];
      lastf <= s_tlast;
    end
    cur    <= cur_next;
    root_a <= root_a_next;
    root_b <= root_b_next;
    rank_a <= rank_a_next;
    rank_b <= rank_b_next;
    taken  <= taken_next;
  end

  // result register, free again once its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && out_free) begin
      m_tdata <= {1'b0, (count >= limit), count[5:0], sum};
      m_tuser <= taken;
      m_tlast <= lastf;
    end
  end

  kruf_forest_mem #(
    .DEPTH (MAX_VERTICES),
    .VW    (VW)
  ) u_mem (
    .clk       (clk),
    .req       (req),
    .epoch     (epoch),
    .rd_parent (rd_parent),
    .rd_rank   (rd_rank)
  );

  kruf_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctl    (acc_ctl),
    .weight (wt),
    .sum    (sum),
    .count  (count)
  );

endmodule

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int MAX_VERTICES   = 64;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int IDLE_LIMIT     = 4000;
  localparam int TAIL_CYCLES    = 100;

  // one edge as it travels on the slave side
  typedef struct packed {
    logic                              last_edge;
    logic                              new_graph;
    logic signed [kruf_pkg::WGT_W-1:0] edge_weight;
    logic [kruf_pkg::VTX_W-1:0]        second_vertex;
    logic [kruf_pkg::VTX_W-1:0]        first_vertex;
  } edge_item_t;

  // expected contents of one result transaction
  typedef struct {
    logic                              taken;
    logic signed [kruf_pkg::SUM_W-1:0] total_weight;
    logic [kruf_pkg::VTX_W-1:0]        edges_taken;
    logic                              tree_complete;
    logic                              final_res;
  } mst_outcome_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [31:0]                 s_tdata = '0;
  logic                        s_tuser = 1'b0;
  logic                        s_tlast = 1'b0;
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [39:0]                 m_tdata;
  logic                        m_tuser;
  logic                        m_tlast;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [kruf_pkg::VCNT_W-1:0] cfg_data = '0;

  // shadow forest and totals
  logic [kruf_pkg::VTX_W-1:0]        forest_parent [MAX_VERTICES];
  logic [kruf_pkg::RANK_W-1:0]       forest_rank [MAX_VERTICES];
  int                                mst_count;
  logic signed [kruf_pkg::SUM_W-1:0] mst_weight;
  int                                span_vertices;

  mst_outcome_t pending_outcomes[$];
  int           mismatches = 0;
  int           sent_edges = 0;
  int           idle_cycles = 0;
  int           stall_left = 0;
  logic         rx_steady = 1'b0;
  bit           tx_steady = 1'b0;

  kruskal_union_find_edge_filter #(
    .MAX_VERTICES(MAX_VERTICES)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // forest predictor

  function automatic void clear_forest();
    for (int i = 0; i < MAX_VERTICES; i++) begin
      forest_parent[i] = kruf_pkg::VTX_W'(i);
      forest_rank[i]   = '0;
    end
    mst_count  = 0;
    mst_weight = '0;
  endfunction

  // root search, then every entry on the path is pointed at the root
  function automatic logic [kruf_pkg::VTX_W-1:0] find_and_compress(
    logic [kruf_pkg::VTX_W-1:0] v);
    logic [kruf_pkg::VTX_W-1:0] root;
    logic [kruf_pkg::VTX_W-1:0] cur;
    logic [kruf_pkg::VTX_W-1:0] nxt;
    int                         steps;
    root  = v;
    steps = 0;
    while (forest_parent[root] != root && steps < MAX_VERTICES) begin
      root = forest_parent[root];
      steps++;
    end
    cur   = v;
    steps = 0;
    while (cur != root && steps < MAX_VERTICES) begin
      nxt                = forest_parent[cur];
      forest_parent[cur] = root;
      cur                = nxt;
      steps++;
    end
    return root;
  endfunction

  function automatic int effective_vertices();
    if (span_vertices == 0) return 1;
    if (span_vertices > MAX_VERTICES) return MAX_VERTICES;
    return span_vertices;
  endfunction

  function automatic mst_outcome_t filter_edge(edge_item_t e);
    mst_outcome_t               o;
    int                         eff;
    int                         limit;
    logic [kruf_pkg::VTX_W-1:0] ra;
    logic [kruf_pkg::VTX_W-1:0] rb;
    longint                     acc;
    if (e.new_graph) clear_forest();
    eff     = effective_vertices();
    limit   = eff - 1;
    o.taken = 1'b0;
    if (mst_count < limit && int'(e.first_vertex) < eff && int'(e.second_vertex) < eff) begin
      ra = find_and_compress(e.first_vertex);
      rb = find_and_compress(e.second_vertex);
      if (ra != rb) begin
        // shorter tree goes under the taller one
        if (forest_rank[ra] < forest_rank[rb]) begin
          forest_parent[ra] = rb;
        end else if (forest_rank[ra] > forest_rank[rb]) begin
          forest_parent[rb] = ra;
        end else begin
          forest_parent[rb] = ra;
          if (forest_rank[ra] != kruf_pkg::RANK_MAX) forest_rank[ra] = forest_rank[ra] + 1'b1;
        end
        // saturating total
        acc = longint'(mst_weight) + longint'($signed(e.edge_weight));
        if (acc > longint'(kruf_pkg::SUM_MAX)) acc = longint'(kruf_pkg::SUM_MAX);
        if (acc < longint'(kruf_pkg::SUM_MIN)) acc = longint'(kruf_pkg::SUM_MIN);
        mst_weight = acc[kruf_pkg::SUM_W-1:0];
        mst_count++;
        o.taken = 1'b1;
      end
    end
    o.total_weight  = mst_weight;
    o.edges_taken   = kruf_pkg::VTX_W'(mst_count);
    o.tree_complete = (mst_count >= limit);
    o.final_res     = e.last_edge;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers

  // mostly short gaps, now and then a long one, none in steady stretches
  function automatic int pick_gap();
    int r;
    if (tx_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_edge(input int a, input int b, input int w, input bit ng, input bit le);
    edge_item_t e;
    int         gap;
    e.first_vertex  = a[kruf_pkg::VTX_W-1:0];
    e.second_vertex = b[kruf_pkg::VTX_W-1:0];
    e.edge_weight   = w[kruf_pkg::WGT_W-1:0];
    e.new_graph     = ng;
    e.last_edge     = le;
    gap = pick_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, e.edge_weight, e.second_vertex, e.first_vertex};
    s_tuser  <= e.new_graph;
    s_tlast  <= e.last_edge;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_outcomes.push_back(filter_edge(e));
    sent_edges++;
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_outcomes();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_vertex_count(input int v);
    drain_outcomes();
    cfg_valid <= 1'b1;
    cfg_data  <= v[kruf_pkg::VCNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    span_vertices = v & 'h7f;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests

  // reset register value, weight extremes, repeated and self-looped edges
  task automatic test_reset_extremes();
    send_edge(0, 63, -32768, 1'b1, 1'b0);
    send_edge(63, 0, 32767, 1'b0, 1'b0);
    send_edge(5, 5, 32767, 1'b0, 1'b0);
    send_edge(62, 63, 32767, 1'b0, 1'b1);
    // carries on in the same graph after the last edge
    send_edge(62, 1, 100, 1'b0, 1'b0);
  endtask

  // vertex count of zero, one, and above the maximum
  task automatic test_degenerate_counts();
    write_vertex_count(0);
    send_edge(0, 0, 1, 1'b1, 1'b0);
    send_edge(0, 1, 5, 1'b0, 1'b1);
    write_vertex_count(1);
    send_edge(0, 0, -7, 1'b1, 1'b1);
    write_vertex_count(127);
    send_edge(0, 63, 7, 1'b1, 1'b0);
    send_edge(63, 62, -9, 1'b0, 1'b1);
  endtask

  // ends out of range, completed tree, register rewritten within a graph
  task automatic test_range_and_completion();
    write_vertex_count(4);
    send_edge(0, 4, 1, 1'b1, 1'b0);
    send_edge(63, 1, 1, 1'b0, 1'b0);
    send_edge(0, 1, 2, 1'b0, 1'b0);
    send_edge(2, 3, 3, 1'b0, 1'b0);
    send_edge(1, 3, 4, 1'b0, 1'b0);
    send_edge(0, 2, 5, 1'b0, 1'b0);
    write_vertex_count(6);
    send_edge(4, 5, 5, 1'b0, 1'b0);
    send_edge(0, 4, 6, 1'b0, 1'b0);
    send_edge(1, 5, 7, 1'b0, 1'b1);
  endtask

  // equal-rank unions build a deep tree, then searches compress it
  task automatic test_rank_depth();
    write_vertex_count(16);
    send_edge(0, 1, 1, 1'b1, 1'b0);
    send_edge(2, 3, 1, 1'b0, 1'b0);
    send_edge(0, 2, 2, 1'b0, 1'b0);
    send_edge(4, 5, 2, 1'b0, 1'b0);
    send_edge(6, 7, 3, 1'b0, 1'b0);
    send_edge(4, 6, 3, 1'b0, 1'b0);
    send_edge(7, 1, 4, 1'b0, 1'b0);
    send_edge(3, 8, 4, 1'b0, 1'b1);
  endtask

  // well-formed sorted graphs with random content, plus some noise
  task automatic test_random_graphs();
    int r;
    int n;
    int eff;
    int m;
    int a;
    int b;
    int w;
    while (sent_edges < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 5) == 0);
      rx_steady <= ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 30) begin
        // new register setting between graphs
        r = $urandom_range(0, 99);
        if (r < 50)      n = $urandom_range(2, 8);
        else if (r < 75) n = $urandom_range(9, 63);
        else if (r < 85) n = MAX_VERTICES;
        else if (r < 90) n = $urandom_range(0, 1);
        else             n = $urandom_range(65, 127);
        write_vertex_count(n);
      end
      if ($urandom_range(0, 99) < 82) begin
        eff = effective_vertices();
        m   = $urandom_range(1, 2 * eff + 2);
        if ($urandom_range(0, 1) == 0) w = $urandom_range(0, 2000) - 32768;
        else                           w = $urandom_range(0, 65535) - 32768;
        for (int i = 0; i < m; i++) begin
          a = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, eff - 1);
          b = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, eff - 1);
          send_edge(a, b, w, i == 0, i == m - 1);
          w = w + $urandom_range(0, 400);
          if (w > 32767) w = 32767;
        end
      end else begin
        // unstructured edges
        m = $urandom_range(1, 20);
        for (int i = 0; i < m; i++) begin
          send_edge($urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 65535) - 32768,
                    $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0);
        end
      end
      // sender holds off until everything has come back
      if ($urandom_range(0, 9) == 0) drain_outcomes();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sink back-pressure: short stalls, a few long ones, steady stretches
  always @(posedge clk) begin
    if (stall_left != 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rx_steady && $urandom_range(0, 9) < 3) begin
      m_tready   <= 1'b0;
      stall_left <= ($urandom_range(0, 11) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin : check_results
    mst_outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result transaction with no edge outstanding");
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        if (m_tuser !== want.taken) begin
          $error("taken: expected %0d, got %0d", want.taken, m_tuser);
          mismatches++;
        end
        if ($signed(m_tdata[31:0]) !== want.total_weight) begin
          $error("total_weight: expected %0d, got %0d", want.total_weight,
                 $signed(m_tdata[31:0]));
          mismatches++;
        end
        if (m_tdata[37:32] !== want.edges_taken) begin
          $error("edges_taken: expected %0d, got %0d", want.edges_taken, m_tdata[37:32]);
          mismatches++;
        end
        if (m_tdata[38] !== want.tree_complete) begin
          $error("tree_complete: expected %0d, got %0d", want.tree_complete, m_tdata[38]);
          mismatches++;
        end
        if (m_tlast !== want.final_res) begin
          $error("final_res: expected %0d, got %0d", want.final_res, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[kruskal_union_find_edge_filter] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    span_vertices = 64;
    clear_forest();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_reset_extremes();
    test_degenerate_counts();
    test_range_and_completion();
    test_rank_depth();
    test_random_graphs();

    drain_outcomes();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("[kruskal_union_find_edge_filter] OK");
    end else begin
      $display("[kruskal_union_find_edge_filter] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/kruf_pkg.sv
hw/rtl/kruf_forest_mem.sv
hw/rtl/kruf_accum.sv
hw/rtl/kruskal_union_find_edge_filter.sv
dv/tb.sv
